// File: rtl/core/ufr_pkg.sv
package ufr_pkg;

  // Payload buffer size and derived widths
  localparam int MAX_PAYLOAD = 256;
  localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
  localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);

  // Frame bytes
  localparam logic [7:0] SYNC_BYTE  = 8'h55;
  localparam logic [7:0] CMD_ERASE  = 8'h01;
  localparam logic [7:0] CMD_WRITE  = 8'h02;
  localparam logic [7:0] CMD_FINISH = 8'h03;

  // Base address bytes at the head of a write payload
  localparam int BASE_BYTES = 4;

  // Result event codes
  localparam logic [1:0] EV_ERASE  = 2'd0;
  localparam logic [1:0] EV_WRITE  = 2'd1;
  localparam logic [1:0] EV_FINISH = 2'd2;
  localparam logic [1:0] EV_ERROR  = 2'd3;

  // Error codes
  localparam logic [1:0] ERR_LENGTH   = 2'd0;
  localparam logic [1:0] ERR_CHECKSUM = 2'd1;
  localparam logic [1:0] ERR_SHORT    = 2'd2;
  localparam logic [1:0] ERR_COMMAND  = 2'd3;

  // Frame parsing phase
  typedef enum logic [2:0] {
    PH_HUNT,
    PH_CMD,
    PH_LENL,
    PH_LENH,
    PH_DATA,
    PH_CHECK
  } phase_t;

  // Sequencer state: taking bytes, or draining write words from the buffer
  typedef enum logic [1:0] {
    ST_RUN,
    ST_RD,
    ST_CAP,
    ST_PUT
  } ctrl_t;

endpackage

// File: rtl/core/ufr_ram.sv
module ufr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/update_frame_receiver_unit.sv
// Update frame receiver.
// rx channel (rx_valid/rx_ready, rx_byte): one received serial byte per
// transaction. Frames are sync 0x55, command, length low, length high,
// payload, checksum (XOR of command, length bytes and payload).
// res channel (res_valid/res_ready): one transaction per event: erase,
// write word, finish or error; last marks the final result of a byte.
// Every result is presented from the registered result outputs.
// Throughput: one byte per cycle while no result is pending. The checksum
// byte of a good write frame with data past the base address starts a drain
// of the payload buffer, one byte read per cycle within a word from the
// single-port-read memory (ST_RD, ST_CAP, then ST_PUT for each word); a full
// frame holds 63 words, and rx_ready stays low for the whole drain.
// Reset (rst, synchronous) returns the parser to sync hunting and empties
// the result register; the payload buffer needs no clearing.
// A stalled res_ready holds the current result, and rx_ready stays low for
// as long as that result waits, whether or not the next byte makes one.
module update_frame_receiver_unit
  import ufr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  output logic        rx_ready,
  input  logic [7:0]  rx_byte,
  output logic        res_valid,
  input  logic        res_ready,
  output logic [1:0]  event_res,
  output logic [1:0]  error_code,
  output logic [31:0] write_address,
  output logic [31:0] write_word,
  output logic [2:0]  byte_count,
  output logic        last
);

  // Parser state
  phase_t             phase, phase_next;
  logic [7:0]         command_code, command_code_next;
  logic [15:0]        frame_length, frame_length_next;
  logic [CNT_W-1:0]   bytes_received, bytes_received_next;
  logic [7:0]         running_xor, running_xor_next;
  logic [31:0]        base_addr, base_addr_next;

  // Drain sequencer
  ctrl_t              st, st_next;
  logic [CNT_W-1:0]   rem, rem_next;
  logic [CNT_W-1:0]   rd_pos, rd_pos_next;
  logic [1:0]         rd_lane, rd_lane_next;
  logic               rd_vld, rd_vld_next;
  logic [1:0]         rd_lane_q, rd_lane_q_next;
  logic [31:0]        word_acc, word_acc_next;
  logic [31:0]        drain_addr, drain_addr_next;

  // Result register
  logic               res_valid_next;
  logic [1:0]         event_res_next, error_code_next;
  logic [31:0]        write_address_next, write_word_next;
  logic [2:0]         byte_count_next;
  logic               last_next;

  // Result load request
  logic               ld;
  logic [1:0]         ld_ev, ld_err;
  logic [31:0]        ld_addr, ld_word;
  logic [2:0]         ld_cnt;
  logic               ld_last;

  // Buffer memory ports
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [7:0]         ram_rdata;

  logic               out_free;
  logic               rx_acc;
  logic [2:0]         cnt;
  logic [15:0]        len_full;
  logic [CNT_W-1:0]   br_inc;
  logic [CNT_W-1:0]   rem_init;

  ufr_ram #(
    .WIDTH(8),
    .DEPTH(MAX_PAYLOAD)
  ) u_buf (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(rx_byte),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Bytes in the word being drained
  assign cnt = (rem > CNT_W'(4)) ? 3'd4 : rem[2:0];

  assign out_free  = !res_valid || res_ready;
  assign rx_ready  = (st == ST_RUN) && out_free;
  assign rx_acc    = rx_valid && rx_ready;
  assign len_full  = {rx_byte, frame_length[7:0]};
  assign br_inc    = bytes_received + CNT_W'(1);
  assign rem_init  = frame_length[CNT_W-1:0] - CNT_W'(BASE_BYTES);
  assign ram_waddr = bytes_received[ADDR_W-1:0];
  assign ram_raddr = rd_pos[ADDR_W-1:0];

  // Next state: parser, drain sequencer and result register
  always_comb begin
    phase_next          = phase;
    command_code_next   = command_code;
    frame_length_next   = frame_length;
    bytes_received_next = bytes_received;
    running_xor_next    = running_xor;
    base_addr_next      = base_addr;
    st_next             = st;
    rem_next            = rem;
    rd_pos_next         = rd_pos;
    rd_lane_next        = rd_lane;
    rd_vld_next         = 1'b0;
    rd_lane_q_next      = rd_lane_q;
    word_acc_next       = word_acc;
    drain_addr_next     = drain_addr;
    res_valid_next      = res_valid && !res_ready;
    event_res_next      = event_res;
    error_code_next     = error_code;
    write_address_next  = write_address;
    write_word_next     = write_word;
    byte_count_next     = byte_count;
    last_next           = last;
    ld      = 1'b0;
    ld_ev   = EV_ERROR;
    ld_err  = ERR_LENGTH;
    ld_addr = '0;
    ld_word = '0;
    ld_cnt  = '0;
    ld_last = 1'b1;
    ram_we  = 1'b0;

    // Read data from the previous cycle's issue lands in its byte lane
    if (rd_vld) begin
      word_acc_next[8*rd_lane_q +: 8] = ram_rdata;
    end

    case (st)
      ST_RUN: begin
        if (rx_acc) begin
          case (phase)
            PH_HUNT: begin
              if (rx_byte == SYNC_BYTE) begin
                phase_next = PH_CMD;
              end
            end
            PH_CMD: begin
              command_code_next = rx_byte;
              running_xor_next  = rx_byte;
              phase_next        = PH_LENL;
            end
            PH_LENL: begin
              frame_length_next = {8'd0, rx_byte};
              running_xor_next  = running_xor ^ rx_byte;
              phase_next        = PH_LENH;
            end
            PH_LENH: begin
              frame_length_next   = len_full;
              running_xor_next    = running_xor ^ rx_byte;
              bytes_received_next = '0;
              if (len_full > 16'(MAX_PAYLOAD)) begin
                ld         = 1'b1;
                ld_ev      = EV_ERROR;
                ld_err     = ERR_LENGTH;
                phase_next = PH_HUNT;
              end else if (len_full == 16'd0) begin
                phase_next = PH_CHECK;
              end else begin
                phase_next = PH_DATA;
              end
            end
            PH_DATA: begin
              ram_we              = 1'b1;
              running_xor_next    = running_xor ^ rx_byte;
              bytes_received_next = br_inc;
              // Base address comes from the first four payload bytes
              if (bytes_received < CNT_W'(BASE_BYTES)) begin
                base_addr_next[8*bytes_received[1:0] +: 8] = rx_byte;
              end
              if (16'(br_inc) >= frame_length) begin
                phase_next = PH_CHECK;
              end
            end
            PH_CHECK: begin
              phase_next = PH_HUNT;
              ld         = 1'b1;
              if (rx_byte != running_xor) begin
                ld_ev  = EV_ERROR;
                ld_err = ERR_CHECKSUM;
              end else if (command_code == CMD_ERASE) begin
                ld_ev = EV_ERASE;
              end else if (command_code == CMD_FINISH) begin
                ld_ev = EV_FINISH;
              end else if (command_code != CMD_WRITE) begin
                ld_ev  = EV_ERROR;
                ld_err = ERR_COMMAND;
              end else if (frame_length < 16'(BASE_BYTES)) begin
                ld_ev  = EV_ERROR;
                ld_err = ERR_SHORT;
              end else if (rem_init == '0) begin
                // Empty write: one zero-count word at the base address
                ld_ev   = EV_WRITE;
                ld_addr = base_addr;
              end else begin
                ld              = 1'b0;
                st_next         = ST_RD;
                rem_next        = rem_init;
                rd_pos_next     = CNT_W'(BASE_BYTES);
                rd_lane_next    = '0;
                word_acc_next   = '0;
                drain_addr_next = base_addr;
              end
            end
            default: begin
              phase_next = PH_HUNT;
            end
          endcase
        end
      end
      ST_RD: begin
        // Issue one buffer read per cycle for the current word
        rd_vld_next    = 1'b1;
        rd_lane_q_next = rd_lane;
        rd_pos_next    = rd_pos + CNT_W'(1);
        if ({1'b0, rd_lane} == cnt - 3'd1) begin
          rd_lane_next = '0;
          st_next      = ST_CAP;
        end else begin
          rd_lane_next = rd_lane + 2'd1;
        end
      end
      ST_CAP: begin
        st_next = ST_PUT;
      end
      ST_PUT: begin
        if (out_free) begin
          ld              = 1'b1;
          ld_ev           = EV_WRITE;
          ld_addr         = drain_addr;
          ld_word         = word_acc;
          ld_cnt          = cnt;
          ld_last         = (rem == CNT_W'(cnt));
          rem_next        = rem - CNT_W'(cnt);
          drain_addr_next = drain_addr + 32'd4;
          word_acc_next   = '0;
          st_next         = (rem == CNT_W'(cnt)) ? ST_RUN : ST_RD;
        end
      end
      default: begin
        st_next = ST_RUN;
      end
    endcase

    // Result register load
    if (ld) begin
      res_valid_next     = 1'b1;
      event_res_next     = ld_ev;
      error_code_next    = ld_err;
      write_address_next = ld_addr;
      write_word_next    = ld_word;
      byte_count_next    = ld_cnt;
      last_next          = ld_last;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      st             <= ST_RUN;
      res_valid      <= 1'b0;
      rd_vld         <= 1'b0;
      command_code   <= '0;
      frame_length   <= '0;
      bytes_received <= '0;
      running_xor    <= '0;
    end else begin
      phase          <= phase_next;
      st             <= st_next;
      res_valid      <= res_valid_next;
      rd_vld         <= rd_vld_next;
      command_code   <= command_code_next;
      frame_length   <= frame_length_next;
      bytes_received <= bytes_received_next;
      running_xor    <= running_xor_next;
    end
  end

  // Payload and datapath registers
  always_ff @(posedge clk) begin
    base_addr     <= base_addr_next;
    rem           <= rem_next;
    rd_pos        <= rd_pos_next;
    rd_lane       <= rd_lane_next;
    rd_lane_q     <= rd_lane_q_next;
    word_acc      <= word_acc_next;
    drain_addr    <= drain_addr_next;
    event_res     <= event_res_next;
    error_code    <= error_code_next;
    write_address <= write_address_next;
    write_word    <= write_word_next;
    byte_count    <= byte_count_next;
    last          <= last_next;
  end

endmodule

// File: bench/tb_update_frame_receiver_unit.sv
module tb_update_frame_receiver_unit
  import ufr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 500_000;
  localparam int RAND_BUDGET = 12;

  // One result transaction as seen on the res channel
  typedef struct packed {
    logic [1:0]  ev;
    logic [1:0]  err;
    logic [31:0] addr;
    logic [31:0] word;
    logic [2:0]  cnt;
    logic        fin;
  } frame_event_t;

  // Frame parser mirror: follows accepted bytes and queues the events due
  class frame_event_board;
    phase_t       ph;
    logic [7:0]   cmd;
    logic [15:0]  flen;
    int unsigned  taken;
    logic [7:0]   csum;
    logic [7:0]   buffer [MAX_PAYLOAD];
    frame_event_t pending_events [$];
    int unsigned  mismatches;

    function new();
      ph         = PH_HUNT;
      cmd        = '0;
      flen       = '0;
      taken      = 0;
      csum       = '0;
      mismatches = 0;
    endfunction

    function void push_event(logic [1:0] ev, logic [1:0] err, logic [31:0] addr,
                             logic [31:0] word, logic [2:0] cnt, logic fin);
      frame_event_t e;
      e.ev   = ev;
      e.err  = err;
      e.addr = addr;
      e.word = word;
      e.cnt  = cnt;
      e.fin  = fin;
      pending_events.push_back(e);
    endfunction

    // Checksum byte: verdict on the whole frame
    function void close_frame(logic [7:0] b);
      logic [31:0] base;
      logic [31:0] addr;
      logic [31:0] word;
      int unsigned remain;
      int unsigned pos;
      int unsigned n;
      if (b != csum) begin
        push_event(EV_ERROR, ERR_CHECKSUM, '0, '0, '0, 1'b1);
      end else if (cmd == CMD_ERASE) begin
        push_event(EV_ERASE, '0, '0, '0, '0, 1'b1);
      end else if (cmd == CMD_FINISH) begin
        push_event(EV_FINISH, '0, '0, '0, '0, 1'b1);
      end else if (cmd != CMD_WRITE) begin
        push_event(EV_ERROR, ERR_COMMAND, '0, '0, '0, 1'b1);
      end else if (flen < BASE_BYTES) begin
        push_event(EV_ERROR, ERR_SHORT, '0, '0, '0, 1'b1);
      end else begin
        base   = {buffer[3], buffer[2], buffer[1], buffer[0]};
        remain = flen - BASE_BYTES;
        if (remain == 0) begin
          // empty write still reports its base address
          push_event(EV_WRITE, '0, base, '0, '0, 1'b1);
        end else begin
          pos  = BASE_BYTES;
          addr = base;
          while (remain > 0) begin
            n    = (remain > 4) ? 4 : remain;
            word = '0;
            for (int i = 0; i < n; i++) word[8*i +: 8] = buffer[pos + i];
            remain -= n;
            pos    += n;
            push_event(EV_WRITE, '0, addr, word, 3'(n), remain == 0);
            addr += 32'd4;
          end
        end
      end
    endfunction

    // Accepted rx transaction
    function void take_byte(logic [7:0] b);
      case (ph)
        PH_HUNT: begin
          if (b == SYNC_BYTE) ph = PH_CMD;
        end
        PH_CMD: begin
          cmd  = b;
          csum = b;
          ph   = PH_LENL;
        end
        PH_LENL: begin
          flen = {8'h00, b};
          csum ^= b;
          ph   = PH_LENH;
        end
        PH_LENH: begin
          flen[15:8] = b;
          csum ^= b;
          taken = 0;
          if (flen > MAX_PAYLOAD) begin
            push_event(EV_ERROR, ERR_LENGTH, '0, '0, '0, 1'b1);
            ph = PH_HUNT;
          end else if (flen == 0) begin
            ph = PH_CHECK;
          end else begin
            ph = PH_DATA;
          end
        end
        PH_DATA: begin
          if (taken < MAX_PAYLOAD) buffer[taken] = b;
          csum ^= b;
          taken++;
          if (taken >= flen) ph = PH_CHECK;
        end
        PH_CHECK: begin
          close_frame(b);
          ph = PH_HUNT;
        end
        default: ph = PH_HUNT;
      endcase
    endfunction

    // Accepted res transaction against the oldest queued event
    function void match_event(frame_event_t got);
      frame_event_t want;
      if (pending_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: ev=%0d err=%0d addr=%h word=%h cnt=%0d last=%0b",
                   got.ev, got.err, got.addr, got.word, got.cnt, got.fin);
        return;
      end
      want = pending_events.pop_front();
      if (got.ev !== want.ev || got.err !== want.err || got.addr !== want.addr ||
          got.word !== want.word || got.cnt !== want.cnt || got.fin !== want.fin) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result mismatch, expected: ev=%0d err=%0d addr=%h word=%h cnt=%0d last=%0b",
                   want.ev, want.err, want.addr, want.word, want.cnt, want.fin);
          $display("                   actual: ev=%0d err=%0d addr=%h word=%h cnt=%0d last=%0b",
                   got.ev, got.err, got.addr, got.word, got.cnt, got.fin);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        rx_valid;
  logic        rx_ready;
  logic [7:0]  rx_byte;
  logic        res_valid;
  logic        res_ready;
  logic [1:0]  event_res;
  logic [1:0]  error_code;
  logic [31:0] write_address;
  logic [31:0] write_word;
  logic [2:0]  byte_count;
  logic        last;

  frame_event_board board;
  logic [7:0]       frame_body [$];
  int               send_idle_pct;
  int               res_stall_pct;
  int               bytes_sent;
  int               cycles;

  update_frame_receiver_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .rx_valid      (rx_valid),
    .rx_ready      (rx_ready),
    .rx_byte       (rx_byte),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .event_res     (event_res),
    .error_code    (error_code),
    .write_address (write_address),
    .write_word    (write_word),
    .byte_count    (byte_count),
    .last          (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL update_frame_receiver_unit");
    $finish;
  end

  // One rx transaction, with an optional idle gap in front
  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < send_idle_pct) begin
      rx_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!rx_ready) @(posedge clk);
    board.take_byte(b);
    bytes_sent++;
  endtask

  task automatic fill_body(input int n);
    frame_body.delete();
    repeat (n) frame_body.push_back(8'($urandom_range(255)));
  endtask

  task automatic load_base(input logic [31:0] base);
    for (int i = 0; i < BASE_BYTES; i++) frame_body[i] = base[8*i +: 8];
  endtask

  // Sync, header, frame_body, then checksum (spoilt when asked)
  task automatic send_frame(input logic [7:0] cmd, input logic [15:0] len, input bit corrupt);
    logic [7:0] sum;
    sum = cmd ^ len[7:0] ^ len[15:8];
    send_byte(SYNC_BYTE);
    send_byte(cmd);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    foreach (frame_body[i]) begin
      sum ^= frame_body[i];
      send_byte(frame_body[i]);
    end
    if (corrupt) sum ^= 8'($urandom_range(1, 255));
    send_byte(sum);
  endtask

  // Mostly well-formed frames with random content, plus noise and broken frames
  task automatic random_traffic(input int budget);
    int          stop_at;
    int          pick;
    int          n;
    logic [7:0]  cmd;
    logic [15:0] len;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 72) begin
        n = $urandom_range(9);
        if (n < 6) cmd = CMD_WRITE;
        else if (n == 6) cmd = CMD_ERASE;
        else if (n == 7) cmd = CMD_FINISH;
        else cmd = 8'($urandom_range(255));
        if ($urandom_range(39) == 0) len = 16'($urandom_range(MAX_PAYLOAD / 2, MAX_PAYLOAD));
        else if (cmd == CMD_WRITE) len = 16'($urandom_range(24));
        else len = 16'($urandom_range(6));
        fill_body(len);
        send_frame(cmd, len, $urandom_range(9) == 0);
      end else if (pick < 82) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
      end else if (pick < 91) begin
        // oversize length: trailing bytes get rescanned for sync
        len = 16'($urandom_range(MAX_PAYLOAD + 1, 16'hFFFF));
        send_byte(SYNC_BYTE);
        send_byte(8'($urandom_range(255)));
        send_byte(len[7:0]);
        send_byte(len[15:8]);
        repeat ($urandom_range(0, 6)) send_byte(8'($urandom_range(255)));
      end else begin
        // frame cut short; the next frame gets swallowed as its tail
        len = 16'($urandom_range(1, 12));
        send_byte(SYNC_BYTE);
        send_byte(8'($urandom_range(1, 3)));
        send_byte(len[7:0]);
        send_byte(len[15:8]);
        repeat ($urandom_range(0, len - 1)) send_byte(8'($urandom_range(255)));
      end
    end
  endtask

  // Result side: random back-pressure, check every accepted transaction
  initial begin
    res_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_valid && res_ready)
        board.match_event({event_res, error_code, write_address, write_word,
                           byte_count, last});
      res_ready <= ($urandom_range(99) >= res_stall_pct);
    end
  end

  initial begin
    board         = new();
    send_idle_pct = 0;
    res_stall_pct = 0;
    bytes_sent    = 0;
    rst      <= 1'b1;
    rx_valid <= 1'b0;
    rx_byte  <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // dropped while hunting, byte extremes
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hAA);
    // erase and finish empty, erase with payload
    frame_body.delete();
    send_frame(CMD_ERASE, 0, 1'b0);
    send_frame(CMD_FINISH, 0, 1'b0);
    fill_body(3);
    send_frame(CMD_ERASE, 3, 1'b0);
    // unknown commands
    frame_body.delete();
    send_frame(8'h00, 0, 1'b0);
    fill_body(1);
    send_frame(8'hFF, 1, 1'b0);
    fill_body(2);
    send_frame(8'h04, 2, 1'b0);
    // short write frames
    for (int k = 0; k < BASE_BYTES; k++) begin
      fill_body(k);
      send_frame(CMD_WRITE, 16'(k), 1'b0);
    end
    // empty write at the top of the address space
    fill_body(4);
    load_base(32'hFFFF_FFFC);
    send_frame(CMD_WRITE, 4, 1'b0);
    fill_body(5);
    send_frame(CMD_WRITE, 5, 1'b0);
    // address wraps past 2^32 mid-frame
    fill_body(13);
    load_base(32'hFFFF_FFF8);
    send_frame(CMD_WRITE, 13, 1'b0);
    // full buffer, longest drain
    fill_body(MAX_PAYLOAD);
    send_frame(CMD_WRITE, 16'(MAX_PAYLOAD), 1'b0);
    // bad checksums
    frame_body.delete();
    send_frame(CMD_FINISH, 0, 1'b1);
    fill_body(10);
    send_frame(CMD_WRITE, 10, 1'b1);
    // length one over the buffer, an erase frame hidden in its payload
    send_byte(SYNC_BYTE);
    send_byte(CMD_WRITE);
    send_byte(8'h01);
    send_byte(8'h01);
    frame_body.delete();
    send_frame(CMD_ERASE, 0, 1'b0);
    // largest length
    send_byte(SYNC_BYTE);
    send_byte(CMD_ERASE);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h00);

    // random phases with different idling
    random_traffic(RAND_BUDGET);
    send_idle_pct = 48;
    random_traffic(RAND_BUDGET);
    send_idle_pct = 0;
    res_stall_pct = 48;
    random_traffic(RAND_BUDGET);
    send_idle_pct = 31;
    res_stall_pct = 31;
    random_traffic(RAND_BUDGET);
    rx_valid <= 1'b0;

    // drain, then watch for stray results
    while (board.pending_events.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("PASS update_frame_receiver_unit");
    end else begin
      $display("FAIL update_frame_receiver_unit");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/ufr_pkg.sv
rtl/core/ufr_ram.sv
rtl/core/update_frame_receiver_unit.sv
bench/tb_update_frame_receiver_unit.sv
